FILE: rtl/core/preemptive_priority_scheduler_top_assert.svh
// Assertion macros shared by the scheduler RTL.
// Each macro expects clk and arst_n in scope at the place of use.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_TOP_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("scheduler invariant violated");
`define PPS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler implication violated");
`define PPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler sequence violated");
`else
`define PPS_ASSERT_ALWAYS(lbl, cond)
`define PPS_ASSERT_IMPL(lbl, ante, cons)
`define PPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/pps_pkg.sv
package pps_pkg;

	// Item kinds on the input channel.
	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_SLICE = 2'd2
	} kind_t;

	localparam int TIME_W = 21;
	localparam int SUM_W  = 25;
	localparam int CNT_W  = 5;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

	// One table entry as held in the slot memory. A slot is finished when its
	// remaining burst is zero; loads never store a zero burst.
	typedef struct packed {
		logic [3:0]  id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
		logic [15:0] prio;
	} slot_rec_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_PICK   = 5'b00100,
		ST_SETTLE = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

endpackage

FILE: rtl/core/pps_ram.sv
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/preemptive_priority_scheduler_top.sv
// Flow: a load goes from idle to the result step, which moves its result into the output
// register. A slice scans the table with one read of the slot memory per loaded slot, picks
// the winner, settles a finishing task when a task runs, and hands over in the result step.
// Throughput: one item at a time; clear and unused kinds are handled in the idle state.
// Reset (arst_n low, asynchronous) empties the table and zeroes time, totals and counts.
// The slot memory needs no clearing pass: the fill count marks which slots are live.
`include "preemptive_priority_scheduler_top_assert.svh"
module preemptive_priority_scheduler_top #(
	parameter int MAX_TASKS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  task_id,
	input  logic [15:0] arrive_at,
	input  logic [15:0] burst_len,
	input  logic [15:0] priority_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ran_valid,
	output logic [3:0]  ran_task,
	output logic [20:0] time_now,
	output logic        finished,
	output logic [20:0] wait_of_finished,
	output logic [24:0] total_wait,
	output logic [4:0]  done_count,
	output logic        load_error
);

	import pps_pkg::*;

	localparam int AW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int RW = $bits(slot_rec_t);

	// Control state. The table is filled from slot zero upward, so loaded_q
	// doubles as the valid mark for every slot.
	state_t              state_q;
	logic [CW-1:0]       loaded_q;
	logic [TIME_W-1:0]   time_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    fin_cnt_q;

	// Scan pipeline: cnt_q issues reads, the _s1 stage tags returning data.
	logic [CW-1:0]       cnt_q;
	logic                rd_valid_s1;
	logic [AW-1:0]       rd_idx_s1;

	// Two running candidates. The "arrived" one is the most urgent slot that has
	// already arrived by the current time. The "earliest" one is ordered by
	// arrival, then priority, then slot; it wins only when nothing has arrived,
	// because then time jumps to its arrival and exactly its arrival group is
	// eligible.
	logic                have_a_q;
	logic [AW-1:0]       a_slot_q;
	slot_rec_t           a_rec_q;
	logic                have_e_q;
	logic [AW-1:0]       e_slot_q;
	slot_rec_t           e_rec_q;

	// Winner bookkeeping between the pick and the settle steps.
	logic [16:0]         win_used_q;
	logic                win_fin_q;

	// Result waiting to move into the output register.
	logic                res_ran_q;
	logic [3:0]          res_task_q;
	logic                res_fin_q;
	logic [TIME_W-1:0]   res_wait_q;
	logic                res_err_q;

	// Output register, so a finished result can wait while the next item is taken.
	logic                out_valid_q;
	logic                ran_valid_q;
	logic [3:0]          ran_task_q;
	logic [TIME_W-1:0]   time_now_q;
	logic                finished_q;
	logic [TIME_W-1:0]   wait_q;
	logic [SUM_W-1:0]    total_wait_q;
	logic [CNT_W-1:0]    done_count_q;
	logic                load_error_q;

	// Slot memory ports.
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	slot_rec_t           ram_wdata;
	slot_rec_t           ram_rdata;
	logic [RW-1:0]       ram_rdata_raw;

	// Combinational helpers.
	logic                in_xfer;
	logic                table_full;
	logic                load_ok;
	logic                rd_unfinished;
	logic                rd_arrived;
	logic                take_a;
	logic                take_e;
	slot_rec_t           win_rec;
	logic [AW-1:0]       win_slot;
	logic [TIME_W-1:0]   t_base;
	logic [TIME_W-1:0]   t_next;
	logic [TIME_W-1:0]   used_ext;
	logic [TIME_W-1:0]   wait_calc;
	logic [SUM_W:0]      sum_ext;
	logic                out_free;

	pps_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_TASKS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q[AW-1:0]),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = slot_rec_t'(ram_rdata_raw);

	assign in_ready   = (state_q == ST_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign table_full = (loaded_q == CW'(MAX_TASKS));
	assign load_ok    = !table_full && (burst_len != 16'd0);
	assign out_free   = !out_valid_q || out_ready;

	// Candidate updates from the slot returning from memory this cycle.
	assign rd_unfinished = (ram_rdata.remaining != 16'd0);
	assign rd_arrived    = ({5'd0, ram_rdata.arrival} <= time_q);
	assign take_a = rd_valid_s1 && rd_unfinished && rd_arrived &&
		(!have_a_q || (ram_rdata.prio < a_rec_q.prio));
	assign take_e = rd_valid_s1 && rd_unfinished &&
		(!have_e_q || (ram_rdata.arrival < e_rec_q.arrival) ||
		((ram_rdata.arrival == e_rec_q.arrival) && (ram_rdata.prio < e_rec_q.prio)));

	// Winner and the time after its slice. When nothing has arrived the time
	// first jumps forward to the earliest arrival.
	assign win_rec  = have_a_q ? a_rec_q : e_rec_q;
	assign win_slot = have_a_q ? a_slot_q : e_slot_q;
	assign t_base   = have_a_q ? time_q : {5'd0, e_rec_q.arrival};
	assign t_next   = (t_base == TIME_MAX) ? t_base : t_base + 21'd1;

	// Waiting time is finish minus arrival minus burst, floored at zero.
	assign used_ext  = {4'd0, win_used_q};
	assign wait_calc = (time_q > used_ext) ? time_q - used_ext : '0;
	assign sum_ext   = {1'b0, sum_q} + {5'd0, wait_calc};

	// Memory writes: a new slot on an accepted load, the shorter remaining
	// burst when a slice is charged to the winner.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = loaded_q[AW-1:0];
		ram_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				ram_wdata.id        = task_id;
				ram_wdata.arrival   = arrive_at;
				ram_wdata.burst     = burst_len;
				ram_wdata.remaining = burst_len;
				ram_wdata.prio      = priority_level;
				ram_we = in_xfer && (kind_t'(kind) == KIND_LOAD) && load_ok;
			end
			ST_PICK: begin
				ram_waddr           = win_slot;
				ram_wdata           = win_rec;
				ram_wdata.remaining = win_rec.remaining - 16'd1;
				ram_we              = have_a_q || have_e_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			loaded_q     <= '0;
			time_q       <= '0;
			sum_q        <= '0;
			fin_cnt_q    <= '0;
			cnt_q        <= '0;
			rd_valid_s1  <= 1'b0;
			rd_idx_s1    <= '0;
			have_a_q     <= 1'b0;
			have_e_q     <= 1'b0;
			a_slot_q     <= '0;
			e_slot_q     <= '0;
			a_rec_q      <= '0;
			e_rec_q      <= '0;
			win_used_q   <= '0;
			win_fin_q    <= 1'b0;
			res_ran_q    <= 1'b0;
			res_task_q   <= '0;
			res_fin_q    <= 1'b0;
			res_wait_q   <= '0;
			res_err_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			ran_valid_q  <= 1'b0;
			ran_task_q   <= '0;
			time_now_q   <= '0;
			finished_q   <= 1'b0;
			wait_q       <= '0;
			total_wait_q <= '0;
			done_count_q <= '0;
			load_error_q <= 1'b0;
		end else begin
			// The result step below sets valid again itself when it hands over.
			if (out_valid_q && out_ready && (state_q != ST_RESULT)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (kind_t'(kind))
							KIND_CLEAR: begin
								loaded_q  <= '0;
								time_q    <= '0;
								sum_q     <= '0;
								fin_cnt_q <= '0;
								cnt_q     <= '0;
							end
							KIND_LOAD: begin
								res_ran_q  <= 1'b0;
								res_task_q <= '0;
								res_fin_q  <= 1'b0;
								res_wait_q <= '0;
								res_err_q  <= !load_ok;
								if (load_ok) begin
									loaded_q <= loaded_q + CW'(1);
								end
								state_q <= ST_RESULT;
							end
							KIND_SLICE: begin
								cnt_q    <= '0;
								have_a_q <= 1'b0;
								have_e_q <= 1'b0;
								state_q  <= ST_SCAN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end

				ST_SCAN: begin
					rd_valid_s1 <= (cnt_q < loaded_q);
					rd_idx_s1   <= cnt_q[AW-1:0];
					if (cnt_q < loaded_q) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (take_a) begin
						have_a_q <= 1'b1;
						a_slot_q <= rd_idx_s1;
						a_rec_q  <= ram_rdata;
					end
					if (take_e) begin
						have_e_q <= 1'b1;
						e_slot_q <= rd_idx_s1;
						e_rec_q  <= ram_rdata;
					end
					if ((cnt_q == loaded_q) && !rd_valid_s1) begin
						state_q <= ST_PICK;
					end
				end

				ST_PICK: begin
					res_err_q  <= 1'b0;
					res_fin_q  <= 1'b0;
					res_wait_q <= '0;
					if (have_a_q || have_e_q) begin
						time_q     <= t_next;
						win_used_q <= {1'b0, win_rec.arrival} + {1'b0, win_rec.burst};
						win_fin_q  <= (win_rec.remaining == 16'd1);
						res_ran_q  <= 1'b1;
						res_task_q <= win_rec.id;
						state_q    <= ST_SETTLE;
					end else begin
						res_ran_q  <= 1'b0;
						res_task_q <= '0;
						state_q    <= ST_RESULT;
					end
				end

				ST_SETTLE: begin
					if (win_fin_q) begin
						res_fin_q  <= 1'b1;
						res_wait_q <= wait_calc;
						sum_q      <= (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[SUM_W-1:0];
						fin_cnt_q  <= fin_cnt_q + CNT_W'(1);
					end
					state_q <= ST_RESULT;
				end

				ST_RESULT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						ran_valid_q  <= res_ran_q;
						ran_task_q   <= res_task_q;
						time_now_q   <= time_q;
						finished_q   <= res_fin_q;
						wait_q       <= res_wait_q;
						total_wait_q <= sum_q;
						done_count_q <= fin_cnt_q;
						load_error_q <= res_err_q;
						state_q      <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign ran_valid        = ran_valid_q;
	assign ran_task         = ran_task_q;
	assign time_now         = time_now_q;
	assign finished         = finished_q;
	assign wait_of_finished = wait_q;
	assign total_wait       = total_wait_q;
	assign done_count       = done_count_q;
	assign load_error       = load_error_q;

	// The fill count never runs past the table, and the scan never issues beyond it.
	`PPS_ASSERT_ALWAYS(a_fill_bound, (loaded_q <= CW'(MAX_TASKS)) && (cnt_q <= loaded_q))
	// An arrived candidate really has arrived when the winner is picked.
	`PPS_ASSERT_IMPL(a_pick_arrived, (state_q == ST_PICK) && have_a_q, {5'd0, a_rec_q.arrival} <= time_q)
	// Time only moves forward while an item is at work.
	`PPS_ASSERT_NEXT(a_time_forward, state_q != ST_IDLE, time_q >= $past(time_q))
	// A completion is only reported for a slice that ran a task, and never with a load error.
	`PPS_ASSERT_IMPL(a_finish_ran, out_valid_q && finished_q, ran_valid_q && !load_error_q)

endmodule
